>>> sv/orderbook_spread_depth_vwap_defines.svh
// assertion macros for the order book statistics block
// used by files that hold concurrent assertions; expects clock and reset in scope
`ifndef ORDERBOOK_SPREAD_DEPTH_VWAP_DEFINES_SVH
`define ORDERBOOK_SPREAD_DEPTH_VWAP_DEFINES_SVH

// condition holds on every clock edge out of reset
`define OSDV_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// condition in one cycle implies another in the next
`define OSDV_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/osdv_pkg.sv
// shared types and constants of the order book statistics block
// no dependencies
`default_nettype none

package osdv_pkg;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_ZERO       = 3'd1;
   localparam logic [2:0] ST_FULL       = 3'd2;
   localparam logic [2:0] ST_NO_BID     = 3'd3;
   localparam logic [2:0] ST_NO_ASK     = 3'd4;
   localparam logic [2:0] ST_CROSSED    = 3'd5;
   localparam logic [2:0] ST_BUY_SHORT  = 3'd6;
   localparam logic [2:0] ST_SELL_SHORT = 3'd7;

   localparam logic REG_BAND   = 1'b0;
   localparam logic REG_TARGET = 1'b1;

   localparam logic SIDE_BID = 1'b0;
   localparam logic SIDE_ASK = 1'b1;

   localparam int BAND_SCALE  = 10000;
   localparam int PRICE_SCALE = 20000;
   localparam int PCT_SCALE   = 2000000;
   localparam int DEPTH_W     = 40;
   localparam int DIV_W       = 80;
   localparam int DIV_CNT_W   = $clog2(DIV_W);
   localparam int DVS_W       = 33;
   localparam int BAND_W      = 48;

   typedef enum logic [1:0] {
      DIV_BUY  = 2'd0,
      DIV_SELL = 2'd1,
      DIV_PCT  = 2'd2
   } div_sel_type;

   typedef enum logic [13:0] {
      S_IDLE     = 14'h0001,
      S_INS_RD   = 14'h0002,
      S_INS_CMP  = 14'h0004,
      S_INS_PUT  = 14'h0008,
      S_FIN      = 14'h0010,
      S_BEST     = 14'h0020,
      S_PREP     = 14'h0040,
      S_W_START  = 14'h0080,
      S_W_MUL    = 14'h0100,
      S_W_ACC    = 14'h0200,
      S_W_END    = 14'h0400,
      S_DIV_GO   = 14'h0800,
      S_DIV_WAIT = 14'h1000,
      S_LOAD     = 14'h2000
   } state_type;

   typedef struct packed {
      logic        accept;
      logic        ins_rd;
      logic        ins_shift;
      logic        ins_put;
      logic        fin_pre;
      logic        fin_rd;
      logic        best;
      logic        prep;
      logic        walk_start;
      logic        walk_mul;
      logic        walk_acc;
      logic        walk_end;
      logic        walk_side;
      logic        short_chk;
      logic        div_start;
      logic        div_latch;
      div_sel_type div_sel;
      logic        load;
   } cmd_type;

   typedef struct packed {
      logic ins_ok;
      logic in_last;
      logic ord_last;
      logic pos_zero;
      logic worse;
      logic pre_err;
      logic crossed;
      logic walk_more;
      logic is_short;
      logic div_done;
   } sts_type;

   typedef struct packed {
      logic [31:0] best_bid;
      logic [31:0] best_ask;
      logic [32:0] mid_doubled;
      logic [31:0] spread;
      logic [20:0] spread_pct_e4;
      logic [39:0] bid_depth;
      logic [39:0] ask_depth;
      logic [47:0] vwap_buy;
      logic [47:0] vwap_sell;
      logic [2:0]  status;
   } result_type;

endpackage

`default_nettype wire

>>> sv/osdv_if.sv
// request and result channel interfaces of the order book statistics block
// no dependencies
`default_nettype none

interface osdv_req_if;
   logic        valid;
   logic        ready;
   logic        side;
   logic [31:0] price;
   logic [31:0] size;
   logic        last;
   modport source (output valid, side, price, size, last, input ready);
   modport sink (input valid, side, price, size, last, output ready);
endinterface

interface osdv_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] best_bid;
   logic [31:0] best_ask;
   logic [32:0] mid_doubled;
   logic [31:0] spread;
   logic [20:0] spread_pct_e4;
   logic [39:0] bid_depth;
   logic [39:0] ask_depth;
   logic [47:0] vwap_buy;
   logic [47:0] vwap_sell;
   logic [2:0]  status;
   modport source (output valid, best_bid, best_ask, mid_doubled, spread, spread_pct_e4,
      bid_depth, ask_depth, vwap_buy, vwap_sell, status, input ready);
   modport sink (input valid, best_bid, best_ask, mid_doubled, spread, spread_pct_e4,
      bid_depth, ask_depth, vwap_buy, vwap_sell, status, output ready);
endinterface

`default_nettype wire

>>> sv/osdv_ram.sv
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module osdv_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> sv/osdv_div.sv
// restoring divider, one quotient bit per cycle
// depends on osdv_pkg
`default_nettype none

module osdv_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [osdv_pkg::DIV_W-1:0]    dividend,
   input  wire logic [osdv_pkg::DVS_W-1:0]    divisor,
   output logic                               done,
   output logic      [osdv_pkg::DIV_W-1:0]    quotient
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [osdv_pkg::DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [osdv_pkg::DVS_W-1:0]        rem_ff, rem_in;
   logic [osdv_pkg::DVS_W-1:0]        dvs_ff, dvs_in;
   logic [osdv_pkg::DIV_W-1:0]        quo_ff, quo_in;
   logic [osdv_pkg::DVS_W:0]          trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      trial   = {rem_ff, quo_ff[osdv_pkg::DIV_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = osdv_pkg::DIV_CNT_W'(osdv_pkg::DIV_W - 1);
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = osdv_pkg::DVS_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[osdv_pkg::DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial[osdv_pkg::DVS_W-1:0];
            quo_in = {quo_ff[osdv_pkg::DIV_W-2:0], 1'b0};
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

>>> sv/osdv_dp.sv
// datapath: sorted tables, band depth and vwap walks, shared divider, result register
// depends on osdv_pkg, osdv_ram, osdv_div and the assertion macro header
`default_nettype none
`include "orderbook_spread_depth_vwap_defines.svh"

module osdv_dp #(
   parameter int TABLE_DEPTH    = 256,
   parameter int VWAP_FRAC_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_side,
   input  wire logic [31:0]          req_price,
   input  wire logic [31:0]          req_size,
   input  wire logic                 req_last,
   input  wire logic [13:0]          band,
   input  wire logic [31:0]          target,
   input  wire osdv_pkg::cmd_type    cmd,
   output osdv_pkg::sts_type         sts,
   output osdv_pkg::result_type      res
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int BW    = osdv_pkg::BAND_W;

   logic             ord_side_ff;
   logic [31:0]      ord_price_ff;
   logic [31:0]      ord_size_ff;
   logic             ord_last_ff;
   logic [CNT_W-1:0] bid_cnt_ff, ask_cnt_ff;
   logic [2:0]       pend_ff;
   logic [IDX_W-1:0] pos_ff;
   logic [2:0]       status_ff;
   logic [31:0]      bb_ff, ba_ff, sp_ff;
   logic [32:0]      m2_ff;
   logic [BW-1:0]    lo_ff, hi_ff;
   logic [52:0]      pctnum_ff;
   logic [CNT_W-1:0] widx_ff;
   logic [31:0]      rem_ff, wsize_ff;
   logic [63:0]      cost_ff, wprod_ff;
   logic [39:0]      dep_ff;
   logic [BW-1:0]    wpp_ff;
   logic [63:0]      cost_buy_ff, cost_sell_ff;
   logic [39:0]      dep_bid_ff, dep_ask_ff;
   logic             short_buy_ff, short_sell_ff;
   logic [47:0]      vb_ff, vs_ff;
   logic [20:0]      pct_ff;
   osdv_pkg::result_type res_ff;
   osdv_pkg::result_type load_res;

   logic [CNT_W-1:0] in_cnt, wcnt;
   logic             in_bad, in_full;
   logic [IDX_W-1:0] raddr;
   logic [63:0]      wdata, bid_rd, ask_rd, ins_rd, walk_rd;
   logic             we_bid, we_ask;
   logic [2:0]       pre_status;
   logic [31:0]      fill;
   logic [40:0]      dep_sum;
   logic             in_band;
   logic [osdv_pkg::DIV_W-1:0] dividend, quotient;
   logic [osdv_pkg::DVS_W-1:0] divisor;
   logic             div_done;
   logic             cnt_in_range, put_has_room, tables_clear;

   assign in_cnt  = req_side ? ask_cnt_ff : bid_cnt_ff;
   assign in_bad  = (req_price == '0) || (req_size == '0);
   assign in_full = (in_cnt == CNT_W'(TABLE_DEPTH));
   assign wcnt    = cmd.walk_side ? ask_cnt_ff : bid_cnt_ff;
   assign ins_rd  = ord_side_ff ? ask_rd : bid_rd;
   assign walk_rd = cmd.walk_side ? ask_rd : bid_rd;

   always_comb begin
      if (pend_ff != osdv_pkg::ST_OK) begin
         pre_status = pend_ff;
      end else if (bid_cnt_ff == '0) begin
         pre_status = osdv_pkg::ST_NO_BID;
      end else if (ask_cnt_ff == '0) begin
         pre_status = osdv_pkg::ST_NO_ASK;
      end else begin
         pre_status = osdv_pkg::ST_OK;
      end
   end

   always_comb begin
      raddr = '0;
      if (cmd.ins_rd) begin
         raddr = pos_ff - 1'b1;
      end else if (cmd.walk_acc) begin
         raddr = widx_ff[IDX_W-1:0];
      end
   end

   assign wdata  = cmd.ins_shift ? ins_rd : {ord_price_ff, ord_size_ff};
   assign we_bid = (cmd.ins_shift || cmd.ins_put) && (ord_side_ff == osdv_pkg::SIDE_BID);
   assign we_ask = (cmd.ins_shift || cmd.ins_put) && (ord_side_ff == osdv_pkg::SIDE_ASK);

   osdv_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_bid_ram (
      .clock (clock),
      .we    (we_bid),
      .waddr (pos_ff),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (bid_rd)
   );

   osdv_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_ask_ram (
      .clock (clock),
      .we    (we_ask),
      .waddr (pos_ff),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (ask_rd)
   );

   always_comb begin
      case (cmd.div_sel)
         osdv_pkg::DIV_BUY: begin
            dividend = osdv_pkg::DIV_W'(cost_buy_ff) << VWAP_FRAC_BITS;
            divisor  = osdv_pkg::DVS_W'(target);
         end
         osdv_pkg::DIV_SELL: begin
            dividend = osdv_pkg::DIV_W'(cost_sell_ff) << VWAP_FRAC_BITS;
            divisor  = osdv_pkg::DVS_W'(target);
         end
         default: begin
            dividend = osdv_pkg::DIV_W'(pctnum_ff);
            divisor  = m2_ff;
         end
      endcase
   end

   osdv_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   assign fill    = (walk_rd[31:0] < rem_ff) ? walk_rd[31:0] : rem_ff;
   assign dep_sum = 41'(dep_ff) + 41'(wsize_ff);
   assign in_band = (wpp_ff >= lo_ff) && (wpp_ff <= hi_ff);

   always_comb begin
      load_res        = '0;
      load_res.status = status_ff;
      if (status_ff == osdv_pkg::ST_OK) begin
         load_res.best_bid      = bb_ff;
         load_res.best_ask      = ba_ff;
         load_res.mid_doubled   = m2_ff;
         load_res.spread        = sp_ff;
         load_res.spread_pct_e4 = pct_ff;
         load_res.bid_depth     = dep_bid_ff;
         load_res.ask_depth     = dep_ask_ff;
         load_res.vwap_buy      = vb_ff;
         load_res.vwap_sell     = vs_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         bid_cnt_ff <= '0;
         ask_cnt_ff <= '0;
         pend_ff    <= osdv_pkg::ST_OK;
      end else if (cmd.load) begin
         bid_cnt_ff <= '0;
         ask_cnt_ff <= '0;
         pend_ff    <= osdv_pkg::ST_OK;
      end else begin
         if (cmd.accept) begin
            if (in_bad) begin
               pend_ff <= osdv_pkg::ST_ZERO;
            end else if (in_full && (pend_ff == osdv_pkg::ST_OK)) begin
               pend_ff <= osdv_pkg::ST_FULL;
            end
         end
         if (cmd.ins_put) begin
            if (ord_side_ff == osdv_pkg::SIDE_ASK) begin
               ask_cnt_ff <= ask_cnt_ff + 1'b1;
            end else begin
               bid_cnt_ff <= bid_cnt_ff + 1'b1;
            end
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         ord_side_ff  <= req_side;
         ord_price_ff <= req_price;
         ord_size_ff  <= req_size;
         ord_last_ff  <= req_last;
         pos_ff       <= in_cnt[IDX_W-1:0];
      end
      if (cmd.ins_shift) begin
         pos_ff <= pos_ff - 1'b1;
      end
      if (cmd.fin_pre) begin
         status_ff <= pre_status;
      end
      if (cmd.best) begin
         bb_ff     <= bid_rd[63:32];
         ba_ff     <= ask_rd[63:32];
         m2_ff     <= 33'(bid_rd[63:32]) + 33'(ask_rd[63:32]);
         sp_ff     <= ask_rd[63:32] - bid_rd[63:32];
         status_ff <= sts.crossed ? osdv_pkg::ST_CROSSED : osdv_pkg::ST_OK;
      end
      if (cmd.prep) begin
         hi_ff     <= BW'(m2_ff) * BW'(osdv_pkg::BAND_SCALE + int'(band));
         lo_ff     <= (band >= 14'(osdv_pkg::BAND_SCALE)) ? '0 :
                      BW'(m2_ff) * BW'(osdv_pkg::BAND_SCALE - int'(band));
         pctnum_ff <= 53'(sp_ff) * 53'(osdv_pkg::PCT_SCALE);
      end
      if (cmd.walk_start) begin
         widx_ff <= CNT_W'(1);
         rem_ff  <= target;
         cost_ff <= '0;
         dep_ff  <= '0;
      end
      if (cmd.walk_mul) begin
         wprod_ff <= 64'(fill) * 64'(walk_rd[63:32]);
         rem_ff   <= rem_ff - fill;
         wpp_ff   <= BW'(walk_rd[63:32]) * BW'(osdv_pkg::PRICE_SCALE);
         wsize_ff <= walk_rd[31:0];
      end
      if (cmd.walk_acc) begin
         cost_ff <= cost_ff + wprod_ff;
         if (in_band) begin
            dep_ff <= dep_sum[40] ? '1 : dep_sum[39:0];
         end
         if (sts.walk_more) begin
            widx_ff <= widx_ff + 1'b1;
         end
      end
      if (cmd.walk_end) begin
         if (cmd.walk_side == osdv_pkg::SIDE_ASK) begin
            cost_buy_ff  <= cost_ff;
            dep_ask_ff   <= dep_ff;
            short_buy_ff <= (rem_ff != '0);
         end else begin
            cost_sell_ff  <= cost_ff;
            dep_bid_ff    <= dep_ff;
            short_sell_ff <= (rem_ff != '0);
         end
      end
      if (cmd.short_chk) begin
         status_ff <= short_buy_ff ? osdv_pkg::ST_BUY_SHORT : osdv_pkg::ST_SELL_SHORT;
      end
      if (cmd.div_latch) begin
         case (cmd.div_sel)
            osdv_pkg::DIV_BUY:  vb_ff  <= (target == '0) ? '0 : quotient[47:0];
            osdv_pkg::DIV_SELL: vs_ff  <= (target == '0) ? '0 : quotient[47:0];
            default:            pct_ff <= quotient[20:0];
         endcase
      end
      if (cmd.load) begin
         res_ff <= load_res;
      end
   end

   assign sts.ins_ok    = !in_bad && !in_full;
   assign sts.in_last   = req_last;
   assign sts.ord_last  = ord_last_ff;
   assign sts.pos_zero  = (pos_ff == '0);
   assign sts.worse     = ord_side_ff ? (ins_rd[63:32] > ord_price_ff) :
                                        (ins_rd[63:32] < ord_price_ff);
   assign sts.pre_err   = (pre_status != osdv_pkg::ST_OK);
   assign sts.crossed   = (bid_rd[63:32] >= ask_rd[63:32]);
   assign sts.walk_more = (widx_ff < wcnt);
   assign sts.is_short  = short_buy_ff || short_sell_ff;
   assign sts.div_done  = div_done;
   assign res           = res_ff;

   assign cnt_in_range = (bid_cnt_ff <= CNT_W'(TABLE_DEPTH)) &&
                         (ask_cnt_ff <= CNT_W'(TABLE_DEPTH));
   assign put_has_room = !cmd.ins_put ||
                         ((ord_side_ff ? ask_cnt_ff : bid_cnt_ff) < CNT_W'(TABLE_DEPTH));
   assign tables_clear = (bid_cnt_ff == '0) && (ask_cnt_ff == '0) &&
                         (pend_ff == osdv_pkg::ST_OK);

   `OSDV_ASSERT_ALWAYS(a_cnt_bound, cnt_in_range, "table count beyond depth")
   `OSDV_ASSERT_ALWAYS(a_put_room, put_has_room, "insert into full table")
   `OSDV_ASSERT_NEXT(a_load_clear, cmd.load, tables_clear, "tables not cleared after result")

endmodule

`default_nettype wire

>>> sv/osdv_ctrl.sv
// controller state machine: insertion loop, final walks, divisions, result handoff
// depends on osdv_pkg
`default_nettype none

module osdv_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   input  wire osdv_pkg::sts_type sts,
   output osdv_pkg::cmd_type      cmd
);

   osdv_pkg::state_type    state_ff, state_in;
   logic                   side_ff, side_in;
   osdv_pkg::div_sel_type  sel_ff, sel_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      side_in      = side_ff;
      sel_in       = sel_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.walk_side = side_ff;
      cmd.div_sel   = sel_ff;
      case (state_ff)
         osdv_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (sts.ins_ok) begin
                  state_in = osdv_pkg::S_INS_RD;
               end else if (sts.in_last) begin
                  state_in = osdv_pkg::S_FIN;
               end
            end
         end
         osdv_pkg::S_INS_RD: begin
            if (sts.pos_zero) begin
               state_in = osdv_pkg::S_INS_PUT;
            end else begin
               cmd.ins_rd = 1'b1;
               state_in   = osdv_pkg::S_INS_CMP;
            end
         end
         osdv_pkg::S_INS_CMP: begin
            if (sts.worse) begin
               cmd.ins_shift = 1'b1;
               state_in      = osdv_pkg::S_INS_RD;
            end else begin
               state_in = osdv_pkg::S_INS_PUT;
            end
         end
         osdv_pkg::S_INS_PUT: begin
            cmd.ins_put = 1'b1;
            state_in    = sts.ord_last ? osdv_pkg::S_FIN : osdv_pkg::S_IDLE;
         end
         osdv_pkg::S_FIN: begin
            cmd.fin_pre = 1'b1;
            if (sts.pre_err) begin
               state_in = osdv_pkg::S_LOAD;
            end else begin
               cmd.fin_rd = 1'b1;
               state_in   = osdv_pkg::S_BEST;
            end
         end
         osdv_pkg::S_BEST: begin
            cmd.best = 1'b1;
            state_in = sts.crossed ? osdv_pkg::S_LOAD : osdv_pkg::S_PREP;
         end
         osdv_pkg::S_PREP: begin
            cmd.prep = 1'b1;
            side_in  = osdv_pkg::SIDE_ASK;
            state_in = osdv_pkg::S_W_START;
         end
         osdv_pkg::S_W_START: begin
            cmd.walk_start = 1'b1;
            state_in       = osdv_pkg::S_W_MUL;
         end
         osdv_pkg::S_W_MUL: begin
            cmd.walk_mul = 1'b1;
            state_in     = osdv_pkg::S_W_ACC;
         end
         osdv_pkg::S_W_ACC: begin
            cmd.walk_acc = 1'b1;
            state_in     = sts.walk_more ? osdv_pkg::S_W_MUL : osdv_pkg::S_W_END;
         end
         osdv_pkg::S_W_END: begin
            cmd.walk_end = 1'b1;
            if (side_ff == osdv_pkg::SIDE_ASK) begin
               side_in  = osdv_pkg::SIDE_BID;
               state_in = osdv_pkg::S_W_START;
            end else begin
               sel_in   = osdv_pkg::DIV_BUY;
               state_in = osdv_pkg::S_DIV_GO;
            end
         end
         osdv_pkg::S_DIV_GO: begin
            if (sts.is_short) begin
               cmd.short_chk = 1'b1;
               state_in      = osdv_pkg::S_LOAD;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = osdv_pkg::S_DIV_WAIT;
            end
         end
         osdv_pkg::S_DIV_WAIT: begin
            if (sts.div_done) begin
               cmd.div_latch = 1'b1;
               case (sel_ff)
                  osdv_pkg::DIV_BUY: begin
                     sel_in   = osdv_pkg::DIV_SELL;
                     state_in = osdv_pkg::S_DIV_GO;
                  end
                  osdv_pkg::DIV_SELL: begin
                     sel_in   = osdv_pkg::DIV_PCT;
                     state_in = osdv_pkg::S_DIV_GO;
                  end
                  default: begin
                     state_in = osdv_pkg::S_LOAD;
                  end
               endcase
            end
         end
         osdv_pkg::S_LOAD: begin
            if (out_free) begin
               cmd.load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = osdv_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = osdv_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= osdv_pkg::S_IDLE;
         side_ff      <= osdv_pkg::SIDE_ASK;
         sel_ff       <= osdv_pkg::DIV_BUY;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         side_ff      <= side_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == osdv_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> sv/orderbook_spread_depth_vwap.sv
// Order book snapshot statistics: spread, band depth and buy/sell vwap.
// Orders enter on req_ch (valid/ready); an order with last set closes the snapshot
// and one result leaves on rsp_ch (valid/ready). Registers depth_band_bp (address 0)
// and the target quantity (address 4) sit on the csr APB port and are to be written
// between snapshots; the block does not enforce this. Each valid order is
// insertion-sorted into a per-side RAM table; every stored entry of the same side
// that must shift past it costs a read and a write through the single read and
// write port of the table RAM. Rejected orders are not stored. After the last order
// the block walks both tables entry by entry, then runs three 80-step serial
// divisions. Error results skip the divisions, and all but the short-quantity ones
// skip the walks too. The result sits in an output register, so a stalled
// receiver only blocks the next snapshot's final result, not the order intake.
// Reset empties both tables and the error flag, sets the registers to 50 and 40,
// and needs no clearing pass; tables also clear after every result.
// Depends on osdv_pkg, osdv_if, osdv_ctrl and osdv_dp.
`default_nettype none

module orderbook_spread_depth_vwap #(
   parameter int TABLE_DEPTH    = 256,
   parameter int VWAP_FRAC_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   osdv_req_if.sink         req_ch,
   osdv_rsp_if.source       rsp_ch,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   logic [13:0] band_ff;
   logic [31:0] target_ff;
   logic        csr_write;

   osdv_pkg::cmd_type    cmd;
   osdv_pkg::sts_type    sts;
   osdv_pkg::result_type res;

   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == osdv_pkg::REG_TARGET) ? target_ff : 32'(band_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         band_ff   <= 14'd50;
         target_ff <= 32'd40;
      end else if (csr_write) begin
         if (csr_paddr[2] == osdv_pkg::REG_TARGET) begin
            target_ff <= csr_pwdata;
         end else begin
            band_ff <= csr_pwdata[13:0];
         end
      end
   end

   osdv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   osdv_dp #(
      .TABLE_DEPTH    (TABLE_DEPTH),
      .VWAP_FRAC_BITS (VWAP_FRAC_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_side  (req_ch.side),
      .req_price (req_ch.price),
      .req_size  (req_ch.size),
      .req_last  (req_ch.last),
      .band      (band_ff),
      .target    (target_ff),
      .cmd       (cmd),
      .sts       (sts),
      .res       (res)
   );

   assign rsp_ch.best_bid      = res.best_bid;
   assign rsp_ch.best_ask      = res.best_ask;
   assign rsp_ch.mid_doubled   = res.mid_doubled;
   assign rsp_ch.spread        = res.spread;
   assign rsp_ch.spread_pct_e4 = res.spread_pct_e4;
   assign rsp_ch.bid_depth     = res.bid_depth;
   assign rsp_ch.ask_depth     = res.ask_depth;
   assign rsp_ch.vwap_buy      = res.vwap_buy;
   assign rsp_ch.vwap_sell     = res.vwap_sell;
   assign rsp_ch.status        = res.status;

endmodule

`default_nettype wire
